// ----- src/fpalu_pkg.sv -----
// Shared types, operation codes and constants for the Q24.8 fixed-point ALU.
package fpalu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
    localparam int PROD_BITS = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_COMPARE  = 4'd6,
        OP_INC      = 4'd7,
        OP_DEC      = 4'd8,
        OP_FROM_INT = 4'd9,
        OP_TO_INT   = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0] operation;
        t_word      operand_a;
        t_word      operand_b;
    } t_in_beat;

    typedef struct packed {
        t_word   result;
        logic    less;
        logic    equal;
        logic    greater;
        t_status status;
    } t_out_beat;

    // Result of the cheap operations plus what later stages still need
    typedef struct packed {
        logic [3:0] op;
        logic       div_live;
        t_out_beat  beat;
    } t_carry;

    // Restoring divider state: num shifts out dividend bits, shifts in quotient bits
    typedef struct packed {
        logic [WORD_BITS-1:0] rem;
        logic [QUO_BITS-1:0]  num;
        logic [WORD_BITS-1:0] nb;
        logic                 neg;
    } t_div;

endpackage

// ----- src/fixed_point_alu_unit.sv -----
// Pipelined Q24.8 fixed-point ALU: add, sub, mul, div, min/max, compare, conversions.
//
//  Port group    Direction  Handshake                  Beat
//  input item    in         i_in_valid / o_in_stall    i_in  (t_in_beat)
//  result item   out        o_out_valid / i_out_stall  o_out (t_out_beat)
//
// One item per cycle sustained while o_in_stall is low; every operation passes the
// input, decode, 40 divider-stage, quotient-rounding and output registers.
// Multiply uses one 32x32 multiplier stage, a magnitude stage and a rounding stage.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload is not reset.
// A stalled result sits in the output register; one more beat lands in a skid
// register, then o_in_stall rises and the whole pipeline holds until it drains.
module fixed_point_alu_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  fpalu_pkg::t_in_beat  i_in,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output fpalu_pkg::t_out_beat o_out,
    input  logic                 i_out_stall
);
    import fpalu_pkg::*;

    localparam int MM_BITS  = PROD_BITS - 1;
    localparam int MQ_BITS  = MM_BITS - FRAC_BITS;
    localparam int QR_BITS  = QUO_BITS + 1;
    localparam int MUL_FOLD = 3;

    localparam logic [MM_BITS-1:0] MUL_HALF   = MM_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [MQ_BITS-1:0] MQ_POS_MAX = MQ_BITS'({1'b0, WORD_MAX});
    localparam logic [MQ_BITS-1:0] MQ_NEG_MAX = MQ_POS_MAX + MQ_BITS'(1);
    localparam logic [QR_BITS-1:0] QR_POS_MAX = QR_BITS'({1'b0, WORD_MAX});
    localparam logic [QR_BITS-1:0] QR_NEG_MAX = QR_POS_MAX + QR_BITS'(1);

    logic en;
    logic out_fire;

    // skid occupancy holds the whole pipeline
    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_beat r_out;
    t_out_beat r_skid;

    assign en          = !r_skid_valid;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_fire    = r_out_valid && !i_out_stall;

    // ---------------- input register ----------------
    logic     r_s1_valid;
    t_in_beat r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_in;
        end
    end

    // ---------------- decode and cheap operations ----------------
    t_word                       a;
    t_word                       b;
    logic signed [WORD_BITS:0]   n_sum;
    logic signed [WORD_BITS:0]   n_dif;
    logic signed [PROD_BITS-1:0] n_prod;
    logic [WORD_BITS-1:0]        n_na;
    logic [WORD_BITS-1:0]        n_nb;
    logic                        n_binary;
    t_carry                      n_cy0;
    t_div                        n_dv0;

    assign a = r_s1.operand_a;
    assign b = r_s1.operand_b;

    always_comb begin
        n_sum    = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        n_dif    = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        n_prod   = PROD_BITS'(a) * PROD_BITS'(b);
        n_binary = r_s1.operation <= OP_COMPARE;
        n_na     = a[WORD_BITS-1] ? -a : a;
        n_nb     = b[WORD_BITS-1] ? -b : b;

        n_cy0.op           = r_s1.operation;
        n_cy0.div_live     = 1'b0;
        n_cy0.beat.result  = '0;
        n_cy0.beat.less    = n_binary && (a < b);
        n_cy0.beat.equal   = n_binary && (a == b);
        n_cy0.beat.greater = n_binary && (a > b);
        n_cy0.beat.status  = ST_OK;

        unique case (r_s1.operation)
            OP_ADD: begin
                if (n_sum[WORD_BITS] != n_sum[WORD_BITS-1]) begin
                    n_cy0.beat.result = n_sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
                    n_cy0.beat.status = ST_OVF;
                end else begin
                    n_cy0.beat.result = n_sum[WORD_BITS-1:0];
                end
            end
            OP_SUB: begin
                if (n_dif[WORD_BITS] != n_dif[WORD_BITS-1]) begin
                    n_cy0.beat.result = n_dif[WORD_BITS] ? WORD_MIN : WORD_MAX;
                    n_cy0.beat.status = ST_OVF;
                end else begin
                    n_cy0.beat.result = n_dif[WORD_BITS-1:0];
                end
            end
            OP_MUL: begin
                // finished in the rounding stages
            end
            OP_DIV: begin
                if (b == '0) begin
                    n_cy0.beat.status = ST_DIV0;
                    if (a > 0) begin
                        n_cy0.beat.result = WORD_MAX;
                    end else if (a < 0) begin
                        n_cy0.beat.result = WORD_MIN;
                    end
                end else begin
                    n_cy0.div_live = 1'b1;
                end
            end
            OP_MIN:     n_cy0.beat.result = (a < b) ? a : b;
            OP_MAX:     n_cy0.beat.result = (a > b) ? a : b;
            OP_COMPARE: begin
                if (a < b) begin
                    n_cy0.beat.result = '1;
                end else if (a > b) begin
                    n_cy0.beat.result = WORD_BITS'(1);
                end
            end
            OP_INC: begin
                if (a == WORD_MAX) begin
                    n_cy0.beat.result = WORD_MAX;
                    n_cy0.beat.status = ST_OVF;
                end else begin
                    n_cy0.beat.result = a + WORD_BITS'(1);
                end
            end
            OP_DEC: begin
                if (a == WORD_MIN) begin
                    n_cy0.beat.result = WORD_MIN;
                    n_cy0.beat.status = ST_OVF;
                end else begin
                    n_cy0.beat.result = a - WORD_BITS'(1);
                end
            end
            OP_FROM_INT: begin
                // top FRAC_BITS+1 bits must all match the sign to fit
                if ((a[WORD_BITS-1 -: FRAC_BITS+1] == '0) ||
                    (a[WORD_BITS-1 -: FRAC_BITS+1] == '1)) begin
                    n_cy0.beat.result = {a[WORD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                end else begin
                    n_cy0.beat.result = a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
                    n_cy0.beat.status = ST_OVF;
                end
            end
            OP_TO_INT:  n_cy0.beat.result = a >>> FRAC_BITS;
            default: begin
                // undefined codes give an all-zero beat
                n_cy0.beat = '0;
            end
        endcase

        n_dv0.rem = '0;
        n_dv0.num = {n_na, {FRAC_BITS{1'b0}}};
        n_dv0.nb  = n_nb;
        n_dv0.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    end

    // ---------------- main pipeline registers ----------------
    logic   r_vl [0:QUO_BITS];
    t_carry r_cy [0:QUO_BITS];
    t_div   r_dv [0:QUO_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_BITS; k++) begin
                r_vl[k] <= 1'b0;
            end
        end else if (en) begin
            r_vl[0] <= r_s1_valid;
            for (int k = 1; k <= QUO_BITS; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cy[0] <= n_cy0;
            r_dv[0] <= n_dv0;
        end
    end

    // ---------------- multiply: product, magnitude, round, saturate ----------------
    logic signed [PROD_BITS-1:0] r_mp;
    logic [PROD_BITS-1:0]        n_mabs;
    logic [MM_BITS-1:0]          r_mm;
    logic                        r_mneg;
    logic [MM_BITS-1:0]          n_mrnd;
    logic [MQ_BITS-1:0]          r_mq;
    logic                        r_mqneg;
    t_carry                      n_cyf;

    assign n_mabs = r_mp[PROD_BITS-1] ? -r_mp : r_mp;
    assign n_mrnd = r_mm + MUL_HALF;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mp    <= n_prod;
            r_mm    <= n_mabs[MM_BITS-1:0];
            r_mneg  <= r_mp[PROD_BITS-1];
            r_mq    <= n_mrnd[MM_BITS-1:FRAC_BITS];
            r_mqneg <= r_mneg;
        end
    end

    // fold the rounded product into the carried beat
    always_comb begin
        n_cyf = r_cy[MUL_FOLD-1];
        if (r_cy[MUL_FOLD-1].op == OP_MUL) begin
            if (!r_mqneg && (r_mq > MQ_POS_MAX)) begin
                n_cyf.beat.result = WORD_MAX;
                n_cyf.beat.status = ST_OVF;
            end else if (r_mqneg && (r_mq > MQ_NEG_MAX)) begin
                n_cyf.beat.result = WORD_MIN;
                n_cyf.beat.status = ST_OVF;
            end else if (r_mqneg) begin
                n_cyf.beat.result = -r_mq[WORD_BITS-1:0];
            end else begin
                n_cyf.beat.result = r_mq[WORD_BITS-1:0];
            end
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 1; k <= QUO_BITS; k++) begin : g_stage
        logic [WORD_BITS:0] n_rem_sh;
        logic [WORD_BITS:0] n_rem_dif;
        logic               n_qbit;

        // rem < nb keeps rem_sh < 2*nb, so the top bit of the difference is the borrow
        always_comb begin
            n_rem_sh  = {r_dv[k-1].rem, r_dv[k-1].num[QUO_BITS-1]};
            n_rem_dif = n_rem_sh - {1'b0, r_dv[k-1].nb};
            n_qbit    = !n_rem_dif[WORD_BITS];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k].rem <= n_qbit ? n_rem_dif[WORD_BITS-1:0] : n_rem_sh[WORD_BITS-1:0];
                r_dv[k].num <= {r_dv[k-1].num[QUO_BITS-2:0], n_qbit};
                r_dv[k].nb  <= r_dv[k-1].nb;
                r_dv[k].neg <= r_dv[k-1].neg;
            end
        end

        if (k == MUL_FOLD) begin : g_fold
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cy[k] <= n_cyf;
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cy[k] <= r_cy[k-1];
                end
            end
        end
    end

    // ---------------- quotient rounding: up when 2*rem >= divisor ----------------
    logic               n_up;
    logic [QR_BITS-1:0] n_qr;
    logic               r_fvl;
    t_carry             r_fcy;
    logic [QR_BITS-1:0] r_fq;
    logic               r_fneg;

    assign n_up = {r_dv[QUO_BITS].rem, 1'b0} >= {1'b0, r_dv[QUO_BITS].nb};
    assign n_qr = {1'b0, r_dv[QUO_BITS].num} + QR_BITS'(n_up);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvl <= 1'b0;
        end else if (en) begin
            r_fvl <= r_vl[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fcy  <= r_cy[QUO_BITS];
            r_fq   <= n_qr;
            r_fneg <= r_dv[QUO_BITS].neg;
        end
    end

    // ---------------- quotient sign and saturation ----------------
    t_out_beat n_beat;

    always_comb begin
        n_beat = r_fcy.beat;
        if (r_fcy.div_live) begin
            if (!r_fneg && (r_fq > QR_POS_MAX)) begin
                n_beat.result = WORD_MAX;
                n_beat.status = ST_OVF;
            end else if (r_fneg && (r_fq > QR_NEG_MAX)) begin
                n_beat.result = WORD_MIN;
                n_beat.status = ST_OVF;
            end else if (r_fneg) begin
                n_beat.result = -r_fq[WORD_BITS-1:0];
            end else begin
                n_beat.result = r_fq[WORD_BITS-1:0];
            end
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_fvl) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (r_fvl) begin
            if (!r_out_valid || out_fire) begin
                r_out <= n_beat;
            end else begin
                r_skid <= n_beat;
            end
        end
    end

endmodule

// ----- src/fpalu_checker.sv -----
// Port-level checks for the fixed-point ALU, bound to the top level.
module fpalu_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input fpalu_pkg::t_out_beat o_out,
    input logic                 i_out_stall
);
    import fpalu_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result beat changed while stalled");

    // input backpressure only comes from a full output pair
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // an empty output register cannot fill the skid by the next cycle
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |=> !o_in_stall)
        else $error("input stalled right after empty output");

    // compare flags are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out.less, o_out.equal, o_out.greater}) <= 1)
        else $error("more than one compare flag set");

endmodule

bind fixed_point_alu_unit fpalu_checker u_fpalu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out       (o_out),
    .i_out_stall (i_out_stall)
);
